// File: rtl/xmodem_crc_frame_receiver_unit_assert.svh
// assertion macros for the xmodem crc frame receiver
// no dependencies; included by xcfr_core, which checks its own logic
`ifndef XMODEM_CRC_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define XMODEM_CRC_FRAME_RECEIVER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define XCFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("xcfr same-cycle check failed");
`define XCFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("xcfr next-cycle check failed");
`else
`define XCFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define XCFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/xcfr_pkg.sv
// shared types, codes and the crc-16 byte update for the xmodem frame receiver
// no dependencies
package xcfr_pkg;

  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CODE_NAK = 8'h15;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0] MAX_PAYLOAD = 8'd128;
  localparam logic [7:0] SEQ_START = 8'd1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       unit_last;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  seq;
    logic [15:0] total;
  } res_t;

  // msb-first crc-16/xmodem over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/xmodem_crc_frame_receiver_unit.sv
// xmodem crc-16 frame receiver: link bytes in, payload/ack/nak/end results out
// throughput: one byte per cycle while the output does not stall; the crc byte update and phase step sit in one
// stage between the input register and the result register
// reset: asynchronous active low, empties both registers and sets sequence to 1
// depends on xcfr_pkg, xcfr_in_stage, xcfr_core, xcfr_out_stage
module xmodem_crc_frame_receiver_unit import xcfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        unit_last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  out_seq_o,
  output logic [15:0] out_total_o
);

  item_t item;
  logic  item_valid;
  logic  consume;
  res_t  res;
  logic  res_valid;
  logic  out_ready;

  xcfr_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .rx_byte_i   (rx_byte_i),
    .unit_last_i (unit_last_i),
    .item_o      (item),
    .item_valid_o(item_valid),
    .consume_i   (consume)
  );

  xcfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_valid_i(item_valid),
    .out_ready_i (out_ready),
    .consume_o   (consume),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  xcfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_valid_i (res_valid),
    .ready_o     (out_ready),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_seq_o   (out_seq_o),
    .out_total_o (out_total_o)
  );

endmodule

// File: rtl/xcfr_in_stage.sv
// input register for link bytes, one beat held until the core takes it
// depends on xcfr_pkg
module xcfr_in_stage import xcfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic  unit_last_i,
  output item_t item_o,
  output logic  item_valid_o,
  input  logic  consume_i
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign stall_o = valid_q && !consume_i;
  assign load    = valid_i && !stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load || consume_i) begin
      valid_q <= load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{rx_byte: rx_byte_i, unit_last: unit_last_i};
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

// File: rtl/xcfr_core.sv
// frame parser: phase machine, crc accumulator, sequence and total tracking
// depends on xcfr_pkg and the assertion macro header
`include "xmodem_crc_frame_receiver_unit_assert.svh"
module xcfr_core import xcfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  item_valid_i,
  input  logic  out_ready_i,
  output logic  consume_o,
  output res_t  res_o,
  output logic  res_valid_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_SEQ, PH_LEN, PH_DATA, PH_CRCH, PH_CRCL, PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crch_q, crch_d;
  logic        bad_q, bad_d;
  logic [15:0] total_q, total_d;

  logic        has_res;
  res_t        res;
  logic [16:0] sum;
  logic [7:0]  cnt_inc;
  logic [7:0]  b;
  logic        last;

  assign b       = item_i.rx_byte;
  assign last    = item_i.unit_last;
  assign sum     = {1'b0, total_q} + {9'd0, len_q};
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    seq_d   = seq_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    crch_d  = crch_q;
    bad_d   = bad_q;
    total_d = total_q;
    has_res = 1'b0;
    res     = '{kind: KIND_NAK, data: CODE_NAK, seq: seq_q, total: total_q};
    case (phase_q)
      PH_IDLE: begin
        if (b == CODE_EOT && last) begin
          seq_d   = SEQ_START;
          total_d = '0;
          has_res = 1'b1;
          res     = '{kind: KIND_END, data: 8'h00, seq: SEQ_START, total: total_q};
        end else if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else if (b == CODE_SOH) begin
          bad_d   = 1'b0;
          crc_d   = '0;
          cnt_d   = '0;
          len_d   = '0;
          phase_d = PH_SEQ;
        end else begin
          bad_d   = 1'b1;
          phase_d = PH_SKIP;
        end
      end
      PH_SEQ: begin
        if (b != seq_q) begin
          bad_d = 1'b1;
        end
        if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        len_d = b;
        if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else if (b > MAX_PAYLOAD) begin
          bad_d   = 1'b1;
          phase_d = PH_SKIP;
        end else begin
          cnt_d   = '0;
          phase_d = (b == 8'd0) ? PH_CRCH : PH_DATA;
        end
      end
      PH_DATA: begin
        if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else begin
          crc_d   = crc_byte(crc_q, b);
          cnt_d   = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_CRCH;
          end
          has_res = 1'b1;
          res     = '{kind: KIND_DATA, data: b, seq: seq_q, total: total_q};
        end
      end
      PH_CRCH: begin
        crch_d = b;
        if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else begin
          phase_d = PH_CRCL;
        end
      end
      PH_CRCL: begin
        if (!last) begin
          bad_d   = 1'b1;
          phase_d = PH_SKIP;
        end else begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
          if (!bad_q && crc_q == {crch_q, b}) begin
            total_d = sum[16] ? 16'hFFFF : sum[15:0];
            seq_d   = seq_q + 8'd1;
            res     = '{kind: KIND_ACK, data: CODE_ACK, seq: seq_d, total: total_d};
          end
        end
      end
      default: begin
        // skipping the rest of a bad unit, also recovers from an unused code
        if (last) begin
          phase_d = PH_IDLE;
          has_res = 1'b1;
        end else begin
          phase_d = PH_SKIP;
        end
      end
    endcase
  end

  assign consume_o   = item_valid_i && (!has_res || out_ready_i);
  assign res_valid_o = item_valid_i && has_res;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seq_q   <= SEQ_START;
      len_q   <= '0;
      cnt_q   <= '0;
      crc_q   <= '0;
      crch_q  <= '0;
      bad_q   <= 1'b0;
      total_q <= '0;
    end else if (consume_o) begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      crch_q  <= crch_d;
      bad_q   <= bad_d;
      total_q <= total_d;
    end
  end

  `XCFR_ASSERT_IMP(a_end_seq_start, clk_i, rst_ni,
    res_valid_o && res_o.kind == KIND_END, res_o.seq == SEQ_START)
  `XCFR_ASSERT_IMP(a_data_in_data_phase, clk_i, rst_ni,
    res_valid_o && res_o.kind == KIND_DATA, phase_q == PH_DATA)
  `XCFR_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni,
    consume_o && item_i.unit_last, phase_q == PH_IDLE)
  `XCFR_ASSERT_NXT(a_total_grows, clk_i, rst_ni,
    consume_o && !(has_res && res.kind == KIND_END), total_q >= $past(total_q))

endmodule

// File: rtl/xcfr_out_stage.sv
// result register driving the output channel
// depends on xcfr_pkg
module xcfr_out_stage import xcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       res_i,
  input  logic       res_valid_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_seq_o,
  output logic [15:0] out_total_o
);

  logic valid_q;
  res_t res_q;
  logic load;

  // free when empty or when the held beat leaves this cycle
  assign ready_o = !valid_q || !stall_i;
  assign load    = res_valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o     = valid_q;
  assign out_kind_o  = res_q.kind;
  assign out_byte_o  = res_q.data;
  assign out_seq_o   = res_q.seq;
  assign out_total_o = res_q.total;

endmodule

// File: test/tb_xmodem_crc_frame_receiver_unit.sv
// self-checking testbench for the xmodem crc-16 frame receiver: randomised link units,
// random idling on both sides and a long receiver hold-off, checked against a predictor
// depends on xcfr_pkg and xmodem_crc_frame_receiver_unit
module tb_xmodem_crc_frame_receiver_unit;
  import xcfr_pkg::*;

  localparam int HOLD_CYCLES    = 60;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 10;
  localparam int PHASE_ITEMS    = 230;
  localparam int SOAK_FRAMES    = 1;

  typedef enum logic [2:0] {
    AWAIT_START, AWAIT_SEQ, AWAIT_LEN, IN_PAYLOAD, AWAIT_CRC_HI, AWAIT_CRC_LO, DISCARD
  } link_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        unit_last_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [7:0]  out_byte_o;
  logic [7:0]  out_seq_o;
  logic [15:0] out_total_o;

  // bytes waiting to go out, and replies the block owes us
  item_t       link_q[$];
  res_t        owed_replies[$];
  logic [7:0]  unit_bytes[$];

  // receiver state as predicted
  link_phase_e rcv_phase;
  logic [7:0]  rcv_seq;
  logic [7:0]  rcv_len;
  logic [7:0]  rcv_count;
  logic [15:0] rcv_crc;
  logic [7:0]  rcv_crc_hi;
  logic        rcv_bad;
  logic [15:0] rcv_total;

  logic [7:0]  gen_seq;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          holds_asked = 0;
  int          holds_granted = 0;
  int          hold_left = 0;
  int          items_queued = 0;
  int          in_beats = 0;
  int          out_beats = 0;
  int          quiet_cycles = 0;
  int          errors = 0;
  int          n_payload = 0;
  int          n_ack = 0;
  int          n_nak = 0;
  int          n_end = 0;
  bit          total_clamped = 1'b0;

  xmodem_crc_frame_receiver_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .rx_byte_i   (rx_byte_i),
    .unit_last_i (unit_last_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .out_seq_o   (out_seq_o),
    .out_total_o (out_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // bit-serial crc-16/xmodem, data fed msb first
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic predict_link_byte(input logic [7:0] b, input logic last);
    res_t        r;
    logic        emit;
    logic        give_nak;
    logic [16:0] sum;
    emit = 1'b0;
    give_nak = 1'b0;
    r = '0;
    case (rcv_phase)
      AWAIT_START: begin
        if (b == CODE_EOT && last) begin
          r = '{KIND_END, 8'h00, SEQ_START, rcv_total};
          emit = 1'b1;
          rcv_seq = SEQ_START;
          rcv_total = '0;
          n_end++;
        end else if (last) begin
          give_nak = 1'b1;
        end else if (b == CODE_SOH) begin
          rcv_bad = 1'b0;
          rcv_crc = '0;
          rcv_count = '0;
          rcv_len = '0;
          rcv_phase = AWAIT_SEQ;
        end else begin
          rcv_bad = 1'b1;
          rcv_phase = DISCARD;
        end
      end
      AWAIT_SEQ: begin
        if (b != rcv_seq) begin
          rcv_bad = 1'b1;
        end
        if (last) begin
          give_nak = 1'b1;
        end else begin
          rcv_phase = AWAIT_LEN;
        end
      end
      AWAIT_LEN: begin
        rcv_len = b;
        if (last) begin
          give_nak = 1'b1;
        end else if (b > MAX_PAYLOAD) begin
          rcv_bad = 1'b1;
          rcv_phase = DISCARD;
        end else begin
          rcv_count = '0;
          rcv_phase = (b == 8'd0) ? AWAIT_CRC_HI : IN_PAYLOAD;
        end
      end
      IN_PAYLOAD: begin
        if (last) begin
          give_nak = 1'b1;
        end else begin
          rcv_crc = crc16_update(rcv_crc, b);
          rcv_count = rcv_count + 8'd1;
          if (rcv_count >= rcv_len) begin
            rcv_phase = AWAIT_CRC_HI;
          end
          r = '{KIND_DATA, b, rcv_seq, rcv_total};
          emit = 1'b1;
          n_payload++;
        end
      end
      AWAIT_CRC_HI: begin
        rcv_crc_hi = b;
        if (last) begin
          give_nak = 1'b1;
        end else begin
          rcv_phase = AWAIT_CRC_LO;
        end
      end
      AWAIT_CRC_LO: begin
        if (!last) begin
          rcv_bad = 1'b1;
          rcv_phase = DISCARD;
        end else if (!rcv_bad && rcv_crc == {rcv_crc_hi, b}) begin
          rcv_phase = AWAIT_START;
          sum = {1'b0, rcv_total} + {9'd0, rcv_len};
          if (sum[16]) begin
            rcv_total = 16'hFFFF;
            total_clamped = 1'b1;
          end else begin
            rcv_total = sum[15:0];
          end
          rcv_seq = rcv_seq + 8'd1;
          r = '{KIND_ACK, CODE_ACK, rcv_seq, rcv_total};
          emit = 1'b1;
          n_ack++;
        end else begin
          give_nak = 1'b1;
        end
      end
      default: begin
        if (last) begin
          give_nak = 1'b1;
        end
      end
    endcase
    if (give_nak) begin
      rcv_phase = AWAIT_START;
      r = '{KIND_NAK, CODE_NAK, rcv_seq, rcv_total};
      emit = 1'b1;
      n_nak++;
    end
    if (emit) begin
      owed_replies.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // sender side: once the previous beat has gone, present the next byte or idle at random
  always @(posedge clk_i or negedge rst_ni) begin : drive_link
    item_t nxt;
    if (!rst_ni) begin
      valid_i <= 1'b0;
      rx_byte_i <= 8'h00;
      unit_last_i <= 1'b0;
      rcv_phase = AWAIT_START;
      rcv_seq = SEQ_START;
      rcv_len = '0;
      rcv_count = '0;
      rcv_crc = '0;
      rcv_crc_hi = '0;
      rcv_bad = 1'b0;
      rcv_total = '0;
    end else begin
      if (valid_i && !stall_o) begin
        predict_link_byte(rx_byte_i, unit_last_i);
        in_beats++;
      end
      if (!valid_i || !stall_o) begin
        if (link_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = link_q.pop_front();
          valid_i <= 1'b1;
          rx_byte_i <= nxt.rx_byte;
          unit_last_i <= nxt.unit_last;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver side: check each result beat, stall at random or for a long hold-off
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    res_t want;
    if (!rst_ni) begin
      stall_i <= 1'b0;
    end else begin
      if (valid_o && !stall_i) begin
        out_beats++;
        if (owed_replies.size() == 0) begin
          $error("unexpected result: kind %0h byte %0h seq %0h total %0h",
                 out_kind_o, out_byte_o, out_seq_o, out_total_o);
          errors++;
        end else begin
          want = owed_replies.pop_front();
          check_field("out_kind", 16'(want.kind), 16'(out_kind_o));
          check_field("out_byte", 16'(want.data), 16'(out_byte_o));
          check_field("out_seq", 16'(want.seq), 16'(out_seq_o));
          check_field("out_total", want.total, out_total_o);
        end
      end
      if (holds_granted != holds_asked) begin
        hold_left = HOLD_CYCLES;
        holds_granted++;
      end
      if (hold_left > 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else begin
        stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((valid_i && !stall_o) || (valid_o && !stall_i))) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no beat for %0d cycles, %0d results still owed", quiet_cycles,
               owed_replies.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic commit_unit();
    item_t it;
    foreach (unit_bytes[i]) begin
      it.rx_byte = unit_bytes[i];
      it.unit_last = (i == unit_bytes.size() - 1);
      link_q.push_back(it);
    end
    items_queued += unit_bytes.size();
    unit_bytes.delete();
  endtask

  task automatic build_frame(input logic [7:0] seq, input logic [7:0] len, input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  b;
    crc = '0;
    unit_bytes.delete();
    unit_bytes.push_back(CODE_SOH);
    unit_bytes.push_back(seq);
    unit_bytes.push_back(len);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      unit_bytes.push_back(b);
      crc = crc16_update(crc, b);
    end
    if (corrupt) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    unit_bytes.push_back(crc[15:8]);
    unit_bytes.push_back(crc[7:0]);
  endtask

  // mostly short frames, now and then a long or full one
  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      return 8'($urandom_range(6));
    end else if (r < 92) begin
      return 8'($urandom_range(40, 7));
    end else if (r < 97) begin
      return 8'($urandom_range(127, 41));
    end
    return MAX_PAYLOAD;
  endfunction

  task automatic queue_random_unit();
    int         pick;
    int         cut;
    logic [7:0] off;
    pick = $urandom_range(99);
    if (pick < 55) begin
      build_frame(gen_seq, pick_len(), 1'b0);
      gen_seq = gen_seq + 8'd1;
    end else if (pick < 63) begin
      build_frame(gen_seq, pick_len(), 1'b1);
    end else if (pick < 69) begin
      off = 8'($urandom_range(255, 1));
      build_frame(gen_seq + off, pick_len(), 1'b0);
    end else if (pick < 75) begin
      unit_bytes.push_back(CODE_EOT);
      gen_seq = SEQ_START;
    end else if (pick < 79) begin
      // oversized length: the rest of the unit is thrown away
      unit_bytes.push_back(CODE_SOH);
      unit_bytes.push_back(gen_seq);
      unit_bytes.push_back(8'($urandom_range(255, int'(MAX_PAYLOAD) + 1)));
      repeat ($urandom_range(4)) unit_bytes.push_back(8'($urandom));
    end else if (pick < 86) begin
      // unit cut short somewhere before the crc low byte
      build_frame(gen_seq, pick_len(), 1'b0);
      cut = $urandom_range(unit_bytes.size() - 1, 1);
      while (unit_bytes.size() > cut) unit_bytes.pop_back();
    end else if (pick < 91) begin
      build_frame(gen_seq, pick_len(), 1'b0);
      repeat ($urandom_range(3, 1)) unit_bytes.push_back(8'($urandom));
    end else if (pick < 94) begin
      unit_bytes.push_back(CODE_EOT);
      repeat ($urandom_range(3, 1)) unit_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(6, 1)) unit_bytes.push_back(8'($urandom));
      if (unit_bytes[0] == CODE_SOH || unit_bytes[0] == CODE_EOT) begin
        unit_bytes[0] = unit_bytes[0] ^ 8'h80;
      end
    end
    commit_unit();
  endtask

  task automatic wait_all_settled();
    while (link_q.size() != 0 || valid_i || owed_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin : run_stimulus
    logic [15:0] dcrc;
    int          goal;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: lone eot, empty frame, extreme payload, oversized length,
    // bad start byte, eot inside a unit, then eot reporting the total
    unit_bytes.push_back(CODE_EOT);
    commit_unit();
    build_frame(SEQ_START, 8'd0, 1'b0);
    commit_unit();
    dcrc = crc16_update(crc16_update(16'h0000, 8'hFF), 8'h00);
    unit_bytes = '{CODE_SOH, 8'd2, 8'd2, 8'hFF, 8'h00, dcrc[15:8], dcrc[7:0]};
    commit_unit();
    unit_bytes = '{CODE_SOH, 8'd3, MAX_PAYLOAD + 8'd1, 8'hAA};
    commit_unit();
    unit_bytes = '{8'h55, 8'hFF};
    commit_unit();
    unit_bytes = '{CODE_EOT, 8'h00};
    commit_unit();
    unit_bytes.push_back(CODE_EOT);
    commit_unit();
    gen_seq = SEQ_START;
    wait_all_settled();

    // idling phases: none, sender only, receiver only, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 76 : (ph == 3) ? 19 : 0;
      stall_pct = (ph == 2) ? 76 : (ph == 3) ? 19 : 0;
      goal = items_queued + PHASE_ITEMS;
      while (items_queued < goal) queue_random_unit();
      wait_all_settled();
    end

    // receiver holds off while the sender keeps offering, so the input backs up
    send_idle_pct = 0;
    stall_pct = 0;
    holds_asked++;
    goal = items_queued + 80;
    while (items_queued < goal) queue_random_unit();
    wait_all_settled();

    // a full-length frame from a fresh transfer, closed by eot with the total
    unit_bytes.push_back(CODE_EOT);
    commit_unit();
    gen_seq = SEQ_START;
    for (int f = 0; f < SOAK_FRAMES; f++) begin
      while (link_q.size() > 512) @(posedge clk_i);
      build_frame(gen_seq, MAX_PAYLOAD, 1'b0);
      commit_unit();
      gen_seq = gen_seq + 8'd1;
    end
    unit_bytes.push_back(CODE_EOT);
    commit_unit();
    wait_all_settled();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("link bytes in: %0d, results out: %0d (payload %0d, ack %0d, nak %0d, end %0d)",
             in_beats, out_beats, n_payload, n_ack, n_nak, n_end);
    $display("total saturation reached: %0s, mismatches: %0d",
             total_clamped ? "yes" : "no", errors);
    if (errors == 0 && owed_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
